[sv/lrupr_pkg.sv]
// shared types and constants for the lru page replacement block
`timescale 1ns / 1ps
`default_nettype none

package lrupr_pkg;

   localparam int PAGE_W      = 16;  // page field width on the request word
   localparam int CFG_W       = 4;   // frames_in_use register width
   localparam int FAULT_W     = 16;  // fault counter width
   localparam int RSP_DATA_W  = 24;  // hit + fault_count padded to whole bytes

   localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

   // per-cell control from the top level
   typedef struct packed {
      logic load;   // a reference is being accepted this cycle
      logic valid;  // this cell holds a resident page
   } cell_ctl_type;

endpackage

`default_nettype wire

[sv/lrupr_cell.sv]
// one recency slot: holds a page, compares it to the key, shifts from its neighbor
`timescale 1ns / 1ps
`default_nettype none

module lrupr_cell #(
   parameter int PAGE_BITS = 16
) (
   input  wire                          clock,
   input  lrupr_pkg::cell_ctl_type      ctl,
   input  wire  [PAGE_BITS-1:0]         key,
   input  wire  [PAGE_BITS-1:0]         prev_page,
   input  wire                          match_in,
   output logic                         match_out,
   output logic [PAGE_BITS-1:0]         page_out
);

   logic [PAGE_BITS-1:0] page_ff;
   logic [PAGE_BITS-1:0] page_in;

   // on an accepted reference a cell shifts unless the hit sits closer to the most-recent end
   always_comb begin
      page_in = page_ff;
      if (ctl.load && !match_in) begin
         page_in = prev_page;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   assign match_out = match_in | (ctl.valid && (page_ff == key));
   assign page_out  = page_ff;

endmodule

`default_nettype wire

[sv/lru_page_replacement.sv]
// lru page replacement set built from a row of recency cells
// Usage:
//   req channel: one word per page reference, tdata = page, tlast = last of run.
//   rsp channel: one word per reference, tdata = {pad, fault_count, hit},
//   tlast copies the request's last flag.
//   csr port: csr_we writes frames_in_use (1..FRAMES; 0 acts as 1, larger values
//   clamp to FRAMES). Write it only while no reference is in flight.
// Timing:
//   the response is registered and appears the cycle after the request word is
//   taken; a new reference can be taken every cycle while rsp_tready is high.
//   The row of cells compares all frames at once and shifts when the word is taken.
// Reset:
//   empties the set, clears the fault counter, frames_in_use returns to 8.
// Stall:
//   the response register holds its word while rsp_tready is low and
//   req_tready drops until it is taken. After a last-of-run word the set and
//   the counter start empty.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_replacement #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [lrupr_pkg::PAGE_W-1:0]         req_tdata,   // page
   input  wire                                  req_tlast,   // last_of_run
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [lrupr_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // hit, fault_count, zero pad
   output logic                                 rsp_tlast,   // last
   input  wire                                  csr_we,
   input  wire  [lrupr_pkg::CFG_W-1:0]          csr_wdata    // frames_in_use
);

   localparam int CNT_W = $clog2(FRAMES + 1);
   localparam int CMP_W = (CNT_W > lrupr_pkg::CFG_W) ? CNT_W : lrupr_pkg::CFG_W;
   localparam int PAD_W = lrupr_pkg::RSP_DATA_W - lrupr_pkg::FAULT_W - 1;

   logic [lrupr_pkg::CFG_W-1:0]    frames_ff;
   logic [CNT_W-1:0]               occ_ff, occ_in;
   logic [lrupr_pkg::FAULT_W-1:0]  fault_ff, fault_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff, rsp_hit_in;
   logic [lrupr_pkg::FAULT_W-1:0]  rsp_fault_ff, rsp_fault_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           accept;
   logic [CNT_W-1:0]               cap;
   logic [CNT_W-1:0]               occ_eff;
   logic [PAGE_BITS-1:0]           key;
   logic                           hit;
   logic [lrupr_pkg::FAULT_W-1:0]  fault_next;

   logic [PAGE_BITS-1:0]           chain_page [FRAMES+1];
   logic                           chain_match [FRAMES+1];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // only the low PAGE_BITS take part in matching
   generate
      if (PAGE_BITS <= lrupr_pkg::PAGE_W) begin : g_key_trunc
         assign key = req_tdata[PAGE_BITS-1:0];
      end else begin : g_key_ext
         assign key = {{(PAGE_BITS - lrupr_pkg::PAGE_W){1'b0}}, req_tdata};
      end
   endgenerate

   // clamp the configured frame count to 1..FRAMES
   always_comb begin
      if (frames_ff == '0) begin
         cap = CNT_W'(1);
      end else if (CMP_W'(frames_ff) > CMP_W'(FRAMES)) begin
         cap = CNT_W'(FRAMES);
      end else begin
         cap = CNT_W'(CMP_W'(frames_ff));
      end
      occ_eff = (occ_ff < cap) ? occ_ff : cap;
   end

   // cell 0 is the most recent slot and loads the key itself
   assign chain_page[0]  = key;
   assign chain_match[0] = 1'b0;

   generate
      for (genvar gi = 0; gi < FRAMES; gi++) begin : g_cell
         lrupr_pkg::cell_ctl_type ctl;
         assign ctl.load  = accept;
         assign ctl.valid = (CNT_W'(gi) < occ_eff);

         lrupr_cell #(
            .PAGE_BITS (PAGE_BITS)
         ) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .key       (key),
            .prev_page (chain_page[gi]),
            .match_in  (chain_match[gi]),
            .match_out (chain_match[gi+1]),
            .page_out  (chain_page[gi+1])
         );
      end
   endgenerate

   assign hit = chain_match[FRAMES];

   always_comb begin
      fault_next = fault_ff;
      if (!hit && (fault_ff != lrupr_pkg::FAULT_MAX)) begin
         fault_next = fault_ff + 1'b1;
      end

      occ_in       = occ_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit;
         rsp_fault_in = fault_next;
         rsp_last_in  = req_tlast;
         if (req_tlast) begin
            occ_in   = '0;
            fault_in = '0;
         end else begin
            fault_in = fault_next;
            if (hit || (occ_eff == cap)) begin
               occ_in = occ_eff;
            end else begin
               occ_in = occ_eff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff    <= lrupr_pkg::CFG_W'(8);
         occ_ff       <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            frames_ff <= csr_wdata;
         end
         occ_ff       <= occ_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hit_ff   <= rsp_hit_in;
      rsp_fault_ff <= rsp_fault_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_fault_ff, rsp_hit_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
